// ===== sv/sfs_pkg.sv =====
package sfs_pkg;

    // field widths fixed by the interface
    localparam int OPCODE_W  = 3;
    localparam int TIME_W    = 24;
    localparam int SLOT_W    = 6;
    localparam int COORD_W   = 8;
    localparam int COUNT_W   = 7;
    localparam int SPEED_W   = 16;
    localparam int FRAC_W    = 8;
    localparam int ELAPSED_W = TIME_W + SPEED_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = SPEED_W;

    localparam int MAX_FRAMES_DEFAULT = 64;
    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(256);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_PLAY    = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_STOP    = 3'd3,
        OP_RESTART = 3'd4,
        OP_WRITE   = 3'd5,
        OP_DESTROY = 3'd6,
        OP_NOP     = 3'd7
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  duration;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
    } frame_entry_t;

    // request to the serial remainder unit
    typedef struct packed {
        logic                 start;
        logic [ELAPSED_W-1:0] dividend;
        logic [ELAPSED_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic                 done;
        logic [ELAPSED_W-1:0] remainder;
    } rem_rsp_t;

endpackage

// ===== sv/sprite_frame_sequencer_core.sv =====
// sprite animation frame sequencer. one command is taken when start is high and busy is low;
// its single result appears on the current_* and is_* ports for exactly one cycle with done
// high, and the receiver cannot stall it. done rises in the cycle busy falls, so the next
// command may be taken in that same cycle. commands other than an active tick pass through
// S_EXEC, S_OUT_RD and S_OUT_FMT. an active tick adds S_ADD after S_EXEC; when looping it then
// totals the clip length, one S_SUM_RD and S_SUM_ACC pair per entry and a last S_SUM_RD; then
// per frame entry visited it does one registered table read and one compare and subtract, or
// only the read when the index already lies beyond the clip. when the elapsed time covers a
// whole lap it is folded back by the bit-serial remainder unit (one bit per cycle over the
// 40-bit elapsed time, then frame 0 is compared again). the frame table has one read port,
// so the table reads in the sequence above happen one at a time. table entries hold nothing
// until written; the table has no clear pass
module sprite_frame_sequencer_core #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration write port
    input  logic                            cfg_write,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,

    // command transfer
    input  logic                            start,
    output logic                            busy,
    input  logic [sfs_pkg::OPCODE_W-1:0]    opcode,
    input  logic [sfs_pkg::TIME_W-1:0]      delta_time,
    input  logic [sfs_pkg::SLOT_W-1:0]      frame_slot,
    input  logic [sfs_pkg::TIME_W-1:0]      frame_duration,
    input  logic [sfs_pkg::COORD_W-1:0]     frame_row,
    input  logic [sfs_pkg::COORD_W-1:0]     frame_column,

    // result transfer, one cycle wide
    output logic                            done,
    output logic [sfs_pkg::SLOT_W-1:0]      current_index,
    output logic [sfs_pkg::COORD_W-1:0]     current_row,
    output logic [sfs_pkg::COORD_W-1:0]     current_column,
    output logic                            is_playing,
    output logic                            is_finished,
    output logic                            is_alive
);

    localparam int TIME_W    = sfs_pkg::TIME_W;
    localparam int SPEED_W   = sfs_pkg::SPEED_W;
    localparam int ELAPSED_W = sfs_pkg::ELAPSED_W;
    localparam int COUNT_W   = sfs_pkg::COUNT_W;
    localparam int SLOT_W    = sfs_pkg::SLOT_W;
    localparam int FRAC_W    = sfs_pkg::FRAC_W;
    localparam int COORD_W   = sfs_pkg::COORD_W;

    // only slots the slot field can reach are stored
    localparam int DEPTH  = (MAX_FRAMES < (1 << SLOT_W)) ? MAX_FRAMES : (1 << SLOT_W);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_LIM =
        COUNT_W'((MAX_FRAMES > COUNT_MAX) ? COUNT_MAX : MAX_FRAMES);
    localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W + 1)'(DEPTH);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_SUM_RD,
        S_SUM_ACC,
        S_LOOP_RD,
        S_LOOP_CMP,
        S_MOD,
        S_OUT_RD,
        S_OUT_FMT
    } state_t;

    // configuration registers
    logic [COUNT_W-1:0]     frame_count_reg;
    logic                   loop_enable_reg;
    logic [SPEED_W-1:0]     speed_q8_reg;

    // sequencer and playback state
    state_t                 state_reg;
    sfs_pkg::opcode_t       op_reg;
    logic [TIME_W-1:0]      delta_reg;
    logic [SLOT_W-1:0]      slot_reg;
    sfs_pkg::frame_entry_t  wr_entry_reg;
    logic [COUNT_W-1:0]     idx_reg;
    logic [COUNT_W-1:0]     sum_idx_reg;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic [ELAPSED_W-1:0]   total_reg;
    logic [ELAPSED_W-1:0]   prod_reg;
    logic                   playing_reg;
    logic                   finished_reg;
    logic                   alive_reg;
    logic                   rem_start_reg;

    // registered result
    logic                   done_reg;
    logic [SLOT_W-1:0]      current_index_reg;
    logic [COORD_W-1:0]     current_row_reg;
    logic [COORD_W-1:0]     current_column_reg;

    // frame table
    sfs_pkg::frame_entry_t  table_mem [DEPTH];
    sfs_pkg::frame_entry_t  rd_data_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      rd_addr;

    logic [COUNT_W-1:0]     eff_count;
    logic                   clip_valid;
    logic                   tick_active;
    logic                   slot_ok;
    logic [ELAPSED_W:0]     add_sum;
    logic [TIME_W-1:0]      rd_dur;
    logic [ELAPSED_W-1:0]   rd_len;
    logic [ELAPSED_W:0]     len_diff;
    logic [COUNT_W:0]       idx_inc;
    logic                   idx_beyond;
    logic                   lap_fold;

    sfs_pkg::rem_req_t      rem_req;
    sfs_pkg::rem_rsp_t      rem_rsp;

    // counts above MAX_FRAMES act as MAX_FRAMES
    assign eff_count  = (frame_count_reg > COUNT_LIM) ? COUNT_LIM : frame_count_reg;
    assign clip_valid = (eff_count != '0);
    assign tick_active = alive_reg && playing_reg && !finished_reg && clip_valid;
    assign slot_ok    = ({1'b0, slot_reg} < SLOT_LIM);

    // saturating add of the scaled delta
    assign add_sum = {1'b0, elapsed_reg} + {1'b0, prod_reg};

    // frame length in the Q32.8 elapsed format, a zero duration counts as one unit
    assign rd_dur   = (rd_data_reg.duration == '0) ? TIME_W'(1) : rd_data_reg.duration;
    assign rd_len   = {{(ELAPSED_W - TIME_W - FRAC_W){1'b0}}, rd_dur, {FRAC_W{1'b0}}};
    assign len_diff = {1'b0, elapsed_reg} - {1'b0, rd_len};

    assign idx_inc    = {1'b0, idx_reg} + (COUNT_W + 1)'(1);
    assign idx_beyond = (idx_reg >= eff_count);
    assign lap_fold   = loop_enable_reg && (idx_reg == '0) && (elapsed_reg >= total_reg);

    // table write and read port selection
    assign mem_we = (state_reg == S_EXEC) && (op_reg == sfs_pkg::OP_WRITE) && slot_ok;
    assign mem_re = (state_reg == S_SUM_RD) || (state_reg == S_LOOP_RD)
                 || (state_reg == S_OUT_RD);
    assign rd_addr = (state_reg == S_SUM_RD) ? sum_idx_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[slot_reg[ADDR_W-1:0]] <= wr_entry_reg;
        if (mem_re)
            rd_data_reg <= table_mem[rd_addr];
    end

    // configuration writes; the user must write only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            loop_enable_reg <= 1'b0;
            speed_q8_reg    <= sfs_pkg::SPEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sfs_pkg::CFG_FRAME_COUNT: frame_count_reg <= cfg_data[COUNT_W-1:0];
                sfs_pkg::CFG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                sfs_pkg::CFG_SPEED:       speed_q8_reg    <= cfg_data[SPEED_W-1:0];
                default:                  ;
            endcase
        end
    end

    // lap folding: elapsed modulo the clip length
    assign rem_req.start    = rem_start_reg;
    assign rem_req.dividend = elapsed_reg;
    assign rem_req.divisor  = total_reg;

    sfs_rem_unit u_rem_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            op_reg             <= sfs_pkg::OP_NOP;
            idx_reg            <= '0;
            sum_idx_reg        <= '0;
            elapsed_reg        <= '0;
            playing_reg        <= 1'b0;
            finished_reg       <= 1'b0;
            alive_reg          <= 1'b1;
            rem_start_reg      <= 1'b0;
            done_reg           <= 1'b0;
            current_index_reg  <= '0;
            current_row_reg    <= '0;
            current_column_reg <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            rem_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg              <= sfs_pkg::opcode_t'(opcode);
                        delta_reg           <= delta_time;
                        slot_reg            <= frame_slot;
                        wr_entry_reg.duration <= frame_duration;
                        wr_entry_reg.row    <= frame_row;
                        wr_entry_reg.column <= frame_column;
                        state_reg           <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_OUT_RD;
                    unique case (op_reg)
                        sfs_pkg::OP_TICK:
                        begin
                            if (tick_active)
                            begin
                                prod_reg  <= ELAPSED_W'(delta_reg * speed_q8_reg);
                                state_reg <= S_ADD;
                            end
                        end
                        sfs_pkg::OP_PLAY:
                        begin
                            if (clip_valid)
                            begin
                                // play on a finished clip starts over
                                if (finished_reg)
                                begin
                                    idx_reg      <= '0;
                                    elapsed_reg  <= '0;
                                    finished_reg <= 1'b0;
                                end
                                playing_reg <= 1'b1;
                            end
                        end
                        sfs_pkg::OP_PAUSE:
                            playing_reg <= 1'b0;
                        sfs_pkg::OP_STOP:
                        begin
                            playing_reg  <= 1'b0;
                            idx_reg      <= '0;
                            elapsed_reg  <= '0;
                            finished_reg <= 1'b0;
                        end
                        sfs_pkg::OP_RESTART:
                        begin
                            idx_reg      <= '0;
                            elapsed_reg  <= '0;
                            finished_reg <= 1'b0;
                            playing_reg  <= clip_valid;
                        end
                        sfs_pkg::OP_WRITE:
                            ;
                        sfs_pkg::OP_DESTROY:
                            alive_reg <= 1'b0;
                        sfs_pkg::OP_NOP:
                            ;
                        default:
                            ;
                    endcase
                end
                S_ADD:
                begin
                    elapsed_reg <= add_sum[ELAPSED_W] ? ELAPSED_MAX : add_sum[ELAPSED_W-1:0];
                    total_reg   <= '0;
                    sum_idx_reg <= '0;
                    state_reg   <= loop_enable_reg ? S_SUM_RD : S_LOOP_RD;
                end
                S_SUM_RD:
                begin
                    // total clip length, one entry per read
                    if (sum_idx_reg == eff_count)
                        state_reg <= S_LOOP_RD;
                    else
                        state_reg <= S_SUM_ACC;
                end
                S_SUM_ACC:
                begin
                    total_reg   <= total_reg + rd_len;
                    sum_idx_reg <= sum_idx_reg + COUNT_W'(1);
                    state_reg   <= S_SUM_RD;
                end
                S_LOOP_RD:
                begin
                    // count lowered under the index: stop as finished, index kept
                    if (idx_beyond)
                    begin
                        finished_reg <= 1'b1;
                        playing_reg  <= 1'b0;
                        state_reg    <= S_OUT_RD;
                    end
                    else
                        state_reg <= S_LOOP_CMP;
                end
                S_LOOP_CMP:
                begin
                    if (lap_fold)
                    begin
                        rem_start_reg <= 1'b1;
                        state_reg     <= S_MOD;
                    end
                    else if (len_diff[ELAPSED_W])
                        state_reg <= S_OUT_RD;
                    else
                    begin
                        elapsed_reg <= len_diff[ELAPSED_W-1:0];
                        if (idx_inc < {1'b0, eff_count})
                        begin
                            idx_reg   <= idx_inc[COUNT_W-1:0];
                            state_reg <= S_LOOP_RD;
                        end
                        else if (loop_enable_reg)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_LOOP_RD;
                        end
                        else
                        begin
                            // last frame of a one-shot clip: hold it
                            finished_reg <= 1'b1;
                            playing_reg  <= 1'b0;
                            state_reg    <= S_OUT_RD;
                        end
                    end
                end
                S_MOD:
                begin
                    if (rem_rsp.done)
                    begin
                        elapsed_reg <= rem_rsp.remainder;
                        state_reg   <= S_LOOP_CMP;
                    end
                end
                S_OUT_RD:
                    state_reg <= S_OUT_FMT;
                S_OUT_FMT:
                begin
                    done_reg          <= 1'b1;
                    current_index_reg <= idx_reg[SLOT_W-1:0];
                    if (idx_beyond)
                    begin
                        current_row_reg    <= '0;
                        current_column_reg <= '0;
                    end
                    else
                    begin
                        current_row_reg    <= rd_data_reg.row;
                        current_column_reg <= rd_data_reg.column;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign current_index  = current_index_reg;
    assign current_row    = current_row_reg;
    assign current_column = current_column_reg;
    assign is_playing     = playing_reg;
    assign is_finished    = finished_reg;
    assign is_alive       = alive_reg;

endmodule

// ===== sv/sfs_rem_unit.sv =====
module sfs_rem_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  sfs_pkg::rem_req_t req,
    output sfs_pkg::rem_rsp_t rsp
);

    localparam int W     = sfs_pkg::ELAPSED_W;
    localparam int CNT_W = $clog2(W);

    typedef enum logic {
        R_IDLE,
        R_RUN
    } rem_state_t;

    rem_state_t        state_reg;
    logic [W-1:0]      dq_reg;
    logic [W-1:0]      div_reg;
    logic [W-1:0]      rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [W:0]        shifted;
    logic [W:0]        diff;

    // one restoring step per cycle
    assign shifted = {rem_reg, dq_reg[W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (req.start)
                    begin
                        dq_reg    <= req.dividend;
                        div_reg   <= req.divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= R_RUN;
                    end
                end
                R_RUN:
                begin
                    if (!diff[W])
                        rem_reg <= diff[W-1:0];
                    else
                        rem_reg <= shifted[W-1:0];
                    dq_reg  <= {dq_reg[W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                end
                default:
                    state_reg <= R_IDLE;
            endcase
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== sv/sfs_assert.sv =====
module sfs_assert (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic is_playing,
    input logic is_finished
);

    // a taken command keeps the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // the result strobe only shows while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // every command ends with its result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // a result lasts exactly one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a finished clip never reports playing
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_finished) |-> !is_playing)
        else $error("finished and playing together");

endmodule

bind sprite_frame_sequencer_core sfs_assert u_sfs_assert (.*);

// ===== test/tb_sprite_frame_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_sprite_frame_sequencer_core;

    import sfs_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // quiet cycles after the last result, well above the slowest tick
    localparam int DRAIN_CYCLES = 600;
    localparam int TARGET_CMDS = 1500;
    localparam int TABLE_DEPTH = MAX_FRAMES_DEFAULT;
    localparam logic [63:0] ELAPSED_MAX = (64'd1 << ELAPSED_W) - 64'd1;
    // the one register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // one entry of the stimulus list: a register write or a command
    typedef struct packed {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        opcode_t               op;
        logic [TIME_W-1:0]     delta;
        logic [SLOT_W-1:0]     slot;
        logic [TIME_W-1:0]     dur;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    column;
    } sprite_job_t;

    // what the block shows after one command
    typedef struct packed {
        logic [SLOT_W-1:0]  index;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic               playing;
        logic               finished;
        logic               alive;
    } frame_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // block inputs start at known values
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  start = 1'b0;
    logic [OPCODE_W-1:0]   opcode = '0;
    logic [TIME_W-1:0]     delta_time = '0;
    logic [SLOT_W-1:0]     frame_slot = '0;
    logic [TIME_W-1:0]     frame_duration = '0;
    logic [COORD_W-1:0]    frame_row = '0;
    logic [COORD_W-1:0]    frame_column = '0;

    logic                  busy;
    logic                  done;
    logic [SLOT_W-1:0]     current_index;
    logic [COORD_W-1:0]    current_row;
    logic [COORD_W-1:0]    current_column;
    logic                  is_playing;
    logic                  is_finished;
    logic                  is_alive;

    sprite_frame_sequencer_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .delta_time     (delta_time),
        .frame_slot     (frame_slot),
        .frame_duration (frame_duration),
        .frame_row      (frame_row),
        .frame_column   (frame_column),
        .done           (done),
        .current_index  (current_index),
        .current_row    (current_row),
        .current_column (current_column),
        .is_playing     (is_playing),
        .is_finished    (is_finished),
        .is_alive       (is_alive)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // animation predictor: own copy of the frame table, clip registers
    // and playback state, updated on every command transfer
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]  sheet_dur [TABLE_DEPTH];
    logic [COORD_W-1:0] sheet_row [TABLE_DEPTH];
    logic [COORD_W-1:0] sheet_col [TABLE_DEPTH];
    int unsigned        anim_index;
    logic [63:0]        anim_elapsed;    // Q32.8 time units
    bit                 anim_playing;
    bit                 anim_finished;
    bit                 anim_alive;
    logic [COUNT_W-1:0] clip_frames;
    bit                 clip_loop;
    logic [SPEED_W-1:0] clip_speed;

    frame_status_t frame_status_q[$];

    // counts above the table depth behave as a full table
    function automatic int unsigned clip_len();
        return (clip_frames > TABLE_DEPTH) ? TABLE_DEPTH : clip_frames;
    endfunction

    // frame length in Q32.8, a zero duration counts as one unit
    function automatic logic [63:0] frame_units(int unsigned i);
        logic [63:0] d;
        d = sheet_dur[i];
        if (d == 0)
            d = 64'd1;
        return d << FRAC_W;
    endfunction

    task automatic restart_clip();
        anim_index = 0;
        anim_elapsed = '0;
        anim_finished = 0;
        anim_playing = (clip_len() != 0);
    endtask

    task automatic animation_tick(input logic [TIME_W-1:0] delta);
        int unsigned n;
        int unsigned i;
        logic [63:0] lap;
        logic [63:0] len;
        bit running;
        n = clip_len();
        if (!anim_alive || !anim_playing || anim_finished || n == 0)
            return;
        anim_elapsed = anim_elapsed + 64'(delta) * 64'(clip_speed);
        if (anim_elapsed > ELAPSED_MAX)
            anim_elapsed = ELAPSED_MAX;
        lap = '0;
        if (clip_loop)
            for (i = 0; i < n; i++)
                lap = lap + frame_units(i);
        running = 1;
        while (running)
        begin
            if (anim_index >= n)
            begin
                // count was lowered under the current frame
                anim_finished = 1;
                anim_playing = 0;
                running = 0;
            end
            else
            begin
                // whole laps from frame 0 land on frame 0 again
                if (clip_loop && anim_index == 0 && anim_elapsed >= lap)
                    anim_elapsed = anim_elapsed % lap;
                len = frame_units(anim_index);
                if (anim_elapsed < len)
                    running = 0;
                else
                begin
                    anim_elapsed = anim_elapsed - len;
                    if (anim_index + 1 < n)
                        anim_index++;
                    else if (clip_loop)
                        anim_index = 0;
                    else
                    begin
                        anim_index = n - 1;
                        anim_finished = 1;
                        anim_playing = 0;
                        running = 0;
                    end
                end
            end
        end
    endtask

    // apply one accepted command and queue the status it must produce
    task automatic advance_animation(input sprite_job_t job);
        frame_status_t st;
        case (job.op)
            OP_TICK:    animation_tick(job.delta);
            OP_PLAY:
                if (clip_len() != 0)
                begin
                    if (anim_finished)
                        restart_clip();
                    else
                        anim_playing = 1;
                end
            OP_PAUSE:   anim_playing = 0;
            OP_STOP:
            begin
                anim_playing = 0;
                anim_index = 0;
                anim_elapsed = '0;
                anim_finished = 0;
            end
            OP_RESTART: restart_clip();
            OP_WRITE:
            begin
                // every 6-bit slot lies inside the table
                sheet_dur[job.slot] = job.dur;
                sheet_row[job.slot] = job.row;
                sheet_col[job.slot] = job.column;
            end
            OP_DESTROY: anim_alive = 0;
            default:    ;
        endcase
        st.index = anim_index[SLOT_W-1:0];
        st.row = (anim_index < clip_len()) ? sheet_row[anim_index] : '0;
        st.column = (anim_index < clip_len()) ? sheet_col[anim_index] : '0;
        st.playing = anim_playing;
        st.finished = anim_finished;
        st.alive = anim_alive;
        frame_status_q.push_back(st);
    endtask

    task automatic write_clip_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_FRAME_COUNT: clip_frames = val[COUNT_W-1:0];
            CFG_LOOP_ENABLE: clip_loop = val[0];
            CFG_SPEED:       clip_speed = val;
            default:         ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus list, filled once before reset is released
    // ------------------------------------------------------------------
    sprite_job_t job_q[$];
    int          cmds_queued = 0;
    int unsigned gen_speed = 256;

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        sprite_job_t j;
        j = '0;
        j.is_reg = 1;
        j.reg_idx = idx;
        j.reg_val = val;
        j.op = OP_NOP;
        if (idx == CFG_SPEED)
            gen_speed = val;
        job_q.push_back(j);
    endtask

    // unused fields carry random values, the block must ignore them
    task automatic queue_cmd(input opcode_t op, input logic [TIME_W-1:0] delta = '0);
        sprite_job_t j;
        j.is_reg = 0;
        j.reg_idx = '0;
        j.reg_val = '0;
        j.op = op;
        j.delta = (op == OP_TICK) ? delta : TIME_W'($urandom);
        j.slot = SLOT_W'($urandom);
        j.dur = TIME_W'($urandom);
        j.row = COORD_W'($urandom);
        j.column = COORD_W'($urandom);
        job_q.push_back(j);
        cmds_queued++;
    endtask

    task automatic queue_frame(input int slot, input logic [TIME_W-1:0] dur,
                               input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
        sprite_job_t j;
        j = '0;
        j.op = OP_WRITE;
        j.delta = TIME_W'($urandom);
        j.slot = SLOT_W'(slot);
        j.dur = dur;
        j.row = row;
        j.column = col;
        job_q.push_back(j);
        cmds_queued++;
    endtask

    // mostly short frames so ticks walk the clip, with rare long ones
    function automatic logic [TIME_W-1:0] random_duration();
        int unsigned r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(1, 12));
    endfunction

    // tick sized to move a few frames at the current speed, now and then huge
    function automatic logic [TIME_W-1:0] tick_delta();
        int unsigned r;
        int unsigned base;
        r = $urandom_range(0, 19);
        if (r == 0)
            return TIME_W'($urandom);
        if (r == 1)
            return '0;
        base = $urandom_range(1, 30) * 256;
        return TIME_W'(base / ((gen_speed == 0) ? 256 : gen_speed) + $urandom_range(0, 2));
    endfunction

    task automatic queue_random_phase();
        int unsigned r;
        int          len;
        int          k;
        r = $urandom_range(0, 9);
        case (r)
            0:       queue_reg(CFG_FRAME_COUNT, 0);
            1:       queue_reg(CFG_FRAME_COUNT, 64);
            2:       queue_reg(CFG_FRAME_COUNT, 127);
            3:       queue_reg(CFG_FRAME_COUNT, 1);
            4:       queue_reg(CFG_FRAME_COUNT, $urandom_range(17, 63));
            default: queue_reg(CFG_FRAME_COUNT, $urandom_range(2, 16));
        endcase
        queue_reg(CFG_LOOP_ENABLE, $urandom_range(0, 1));
        r = $urandom_range(0, 9);
        case (r)
            0:       queue_reg(CFG_SPEED, 0);
            1:       queue_reg(CFG_SPEED, 16'hFFFF);
            2:       queue_reg(CFG_SPEED, 1);
            3, 4, 5: queue_reg(CFG_SPEED, 256);
            6:       queue_reg(CFG_SPEED, 128);
            7:       queue_reg(CFG_SPEED, 512);
            default: queue_reg(CFG_SPEED, $urandom_range(64, 1024));
        endcase
        // a playing clip fed mostly with ticks, the rest scattered events
        queue_cmd(OP_RESTART);
        len = $urandom_range(40, 120);
        for (k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                queue_cmd(OP_TICK, tick_delta());
            else if (r < 73)
                queue_cmd(OP_PLAY);
            else if (r < 77)
                queue_cmd(OP_PAUSE);
            else if (r < 80)
                queue_cmd(OP_STOP);
            else if (r < 85)
                queue_cmd(OP_RESTART);
            else if (r < 95)
                queue_frame($urandom_range(0, TABLE_DEPTH - 1), random_duration(),
                            COORD_W'($urandom), COORD_W'($urandom));
            else
                queue_cmd(OP_NOP);
        end
    endtask

    task automatic build_stimulus();
        int s;
        // no clip yet: every event leaves index and coordinates at zero
        queue_cmd(OP_TICK, 5);
        queue_cmd(OP_PLAY);
        queue_cmd(OP_RESTART);
        queue_cmd(OP_PAUSE);
        queue_cmd(OP_STOP);
        queue_cmd(OP_NOP);
        // known head of the table, frame 0 with zero duration
        queue_frame(0, '0, 8'hFF, 8'h00);
        for (s = 1; s < 8; s++)
            queue_frame(s, 24'd3, COORD_W'($urandom), COORD_W'($urandom));
        // rest of the table, short frames so a long tick can reach the end
        for (s = 8; s < TABLE_DEPTH - 1; s++)
            queue_frame(s, TIME_W'($urandom_range(0, 15)), COORD_W'($urandom),
                        COORD_W'($urandom));
        queue_frame(TABLE_DEPTH - 1, '1, '1, '1);

        // one-shot clip of 8, then the count cut below the current frame
        queue_reg(CFG_FRAME_COUNT, 8);
        queue_reg(CFG_LOOP_ENABLE, 0);
        queue_reg(CFG_SPEED, 256);
        queue_cmd(OP_RESTART);
        queue_cmd(OP_TICK, 0);
        queue_cmd(OP_TICK, 17);
        queue_reg(CFG_FRAME_COUNT, 3);
        queue_cmd(OP_TICK, 1);
        // play on a finished clip starts over, a long tick ends it
        queue_cmd(OP_PLAY);
        queue_cmd(OP_TICK, 1000);
        queue_cmd(OP_TICK, 5);
        queue_cmd(OP_STOP);
        queue_cmd(OP_PLAY);
        queue_cmd(OP_TICK, 2);
        queue_cmd(OP_PAUSE);
        queue_cmd(OP_TICK, 2);
        queue_cmd(OP_PLAY);

        // oversized count, park on the long last frame, then saturate
        queue_reg(CFG_FRAME_COUNT, 127);
        queue_cmd(OP_RESTART);
        queue_cmd(OP_TICK, '1);
        queue_reg(CFG_SPEED, 16'hFFFF);
        queue_cmd(OP_TICK, '1);
        // looping with laps folded away
        queue_reg(CFG_LOOP_ENABLE, 1);
        queue_cmd(OP_RESTART);
        queue_cmd(OP_TICK, '1);
        queue_cmd(OP_TICK, 1);
        queue_reg(CFG_SPEED, 0);
        queue_cmd(OP_TICK, 50);
        queue_reg(CFG_SPARE, 16'hFFFF);

        while (cmds_queued < TARGET_CMDS)
            queue_random_phase();

        // destroy last: ticks die, other events keep working
        queue_reg(CFG_FRAME_COUNT, 6);
        queue_reg(CFG_SPEED, 256);
        queue_cmd(OP_RESTART);
        queue_cmd(OP_TICK, 4);
        queue_cmd(OP_DESTROY);
        queue_cmd(OP_TICK, 4);
        queue_cmd(OP_PAUSE);
        queue_cmd(OP_PLAY);
        queue_cmd(OP_TICK, 9);
        queue_frame(2, 24'd5, 8'h5A, 8'hA5);
        queue_cmd(OP_RESTART);
        queue_cmd(OP_STOP);
    endtask

    // ------------------------------------------------------------------
    // driver: one command transfer at a time, register writes only when
    // every result of the earlier commands has come back
    // ------------------------------------------------------------------
    sprite_job_t driven_job;
    logic        next_start;
    logic        next_cfg;
    int          gap_left;
    int          burst_left;
    int          cmds_accepted;
    int          results_seen;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_write <= 1'b0;
            gap_left = 0;
            burst_left = 0;
            cmds_accepted = 0;
            results_seen = 0;
            anim_index = 0;
            anim_elapsed = '0;
            anim_playing = 0;
            anim_finished = 0;
            anim_alive = 1;
            clip_frames = '0;
            clip_loop = 0;
            clip_speed = SPEED_RESET;
        end
        else
        begin
            next_start = start;
            next_cfg = 1'b0;
            if (done)
                results_seen++;
            // command transfer at this edge
            if (start && !busy)
            begin
                advance_animation(driven_job);
                cmds_accepted++;
                next_start = 1'b0;
                // idle before the next command, with bursts of none
                if (burst_left != 0)
                begin
                    burst_left--;
                    gap_left = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    burst_left = $urandom_range(10, 40);
                    gap_left = 0;
                end
                else
                    gap_left = $urandom_range(0, 9);
            end
            if (!next_start)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (job_q.size() != 0)
                begin
                    if (!job_q[0].is_reg)
                    begin
                        driven_job = job_q.pop_front();
                        opcode <= driven_job.op;
                        delta_time <= driven_job.delta;
                        frame_slot <= driven_job.slot;
                        frame_duration <= driven_job.dur;
                        frame_row <= driven_job.row;
                        frame_column <= driven_job.column;
                        next_start = 1'b1;
                    end
                    else if (cmds_accepted == results_seen && !busy)
                    begin
                        driven_job = job_q.pop_front();
                        cfg_index <= driven_job.reg_idx;
                        cfg_data <= driven_job.reg_val;
                        write_clip_register(driven_job.reg_idx, driven_job.reg_val);
                        next_cfg = 1'b1;
                    end
                end
            end
            start <= next_start;
            cfg_write <= next_cfg;
        end
    end

    // ------------------------------------------------------------------
    // monitor: each done pulse is one result transfer, checked against
    // the oldest predicted status
    // ------------------------------------------------------------------
    int            failures = 0;
    int            results_checked = 0;
    frame_status_t want;

    function automatic void report_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned got_val);
        if (exp_val != got_val)
            report_failure($sformatf("result %0d %s mismatch: expected %0h, got %0h",
                                     results_checked, name, exp_val, got_val));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_checked++;
            if (frame_status_q.size() == 0)
                report_failure($sformatf("result %0d with no command pending",
                                         results_checked));
            else
            begin
                want = frame_status_q.pop_front();
                check_field("current_index", want.index, current_index);
                check_field("current_row", want.row, current_row);
                check_field("current_column", want.column, current_column);
                check_field("is_playing", want.playing, is_playing);
                check_field("is_finished", want.finished, is_finished);
                check_field("is_alive", want.alive, is_alive);
            end
        end
    end

    // watchdog: any transfer or register write counts as progress
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done || (start && !busy) || cfg_write)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d idle cycles", stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // sample between edges so the driver and monitor have settled
        do
            @(negedge clk);
        while (job_q.size() != 0 || start || cmds_accepted != results_seen);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (frame_status_q.size() != 0)
            report_failure($sformatf("%0d results never arrived", frame_status_q.size()));
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sfs_pkg.sv
sv/sfs_rem_unit.sv
sv/sprite_frame_sequencer_core.sv
sv/sfs_assert.sv
test/tb_sprite_frame_sequencer_core.sv
